### src/hssb_pkg.sv
package hssb_pkg;

   localparam int SYMBOL_LEN = 32;
   localparam int IDX_W = $clog2(SYMBOL_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_LEN - 1);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(0);
   localparam logic [IDX_W-1:0] MIRROR_END_IDX = IDX_W'(1);
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;

   typedef struct packed {
      logic signed [15:0] im;
      logic signed [15:0] re;
   } sample_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_SAMPLE,
      SEL_CONJ
   } out_sel_type;

   typedef struct packed {
      logic             load;
      out_sel_type      sel;
      logic             last;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
   } cmd_type;

   typedef struct packed {
      logic load_ok;
   } status_type;

   function automatic logic signed [15:0] sat_negate(input logic signed [15:0] v);
      logic signed [15:0] r;
      if (v == SAMPLE_MIN) begin
         r = SAMPLE_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

### src/hssb_if.sv
interface hssb_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] in_re;
   logic signed [15:0] in_im;

   modport source (output valid, output in_re, output in_im, input ready);
   modport sink (input valid, input in_re, input in_im, output ready);
endinterface

interface hssb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_re;
   logic signed [15:0] out_im;
   logic               last_of_symbol;

   modport source (output valid, output out_re, output out_im, output last_of_symbol,
                   input ready);
   modport sink (input valid, input out_re, input out_im, input last_of_symbol,
                 output ready);
endinterface

### src/hssb_ctrl.sv
module hssb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hssb_pkg::status_type status,
   output hssb_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_PASS,
      ST_SEP,
      ST_CONJ
   } state_type;

   state_type                    state_ff, state_in;
   logic [hssb_pkg::IDX_W-1:0]   pos_ff, pos_in;
   logic [hssb_pkg::IDX_W-1:0]   rd_addr_ff, rd_addr_in;
   logic                         accept;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      rd_addr_in = hssb_pkg::LAST_IDX;
      req_ready  = 1'b0;
      accept     = 1'b0;
      cmd        = '0;
      cmd.sel    = hssb_pkg::SEL_ZERO;
      cmd.wr_addr = pos_ff;
      case (state_ff)
         ST_PASS: begin
            req_ready = status.load_ok;
            accept    = req_valid && status.load_ok;
            cmd.load  = accept;
            cmd.sel   = (pos_ff == hssb_pkg::FIRST_IDX) ? hssb_pkg::SEL_ZERO
                                                        : hssb_pkg::SEL_SAMPLE;
            cmd.wr_en = accept && (pos_ff != hssb_pkg::FIRST_IDX);
            if (accept) begin
               if (pos_ff == hssb_pkg::LAST_IDX) begin
                  pos_in   = hssb_pkg::FIRST_IDX;
                  state_in = ST_SEP;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_SEP: begin
            // separator zero; store read of the top entry settles meanwhile
            cmd.load = status.load_ok;
            cmd.sel  = hssb_pkg::SEL_ZERO;
            if (status.load_ok) begin
               state_in = ST_CONJ;
            end
         end
         ST_CONJ: begin
            cmd.load   = status.load_ok;
            cmd.sel    = hssb_pkg::SEL_CONJ;
            cmd.last   = (rd_addr_ff == hssb_pkg::MIRROR_END_IDX);
            rd_addr_in = rd_addr_ff;
            if (status.load_ok) begin
               rd_addr_in = rd_addr_ff - 1'b1;
               if (rd_addr_ff == hssb_pkg::MIRROR_END_IDX) begin
                  state_in = ST_PASS;
               end
            end
         end
         default: begin
            state_in = ST_PASS;
         end
      endcase
      cmd.rd_addr = rd_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_PASS;
         pos_ff     <= hssb_pkg::FIRST_IDX;
         rd_addr_ff <= hssb_pkg::LAST_IDX;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         rd_addr_ff <= rd_addr_in;
      end
   end

   a_last_sample_to_sep: assert property (@(posedge clock) disable iff (reset)
      accept && (pos_ff == hssb_pkg::LAST_IDX) |=> state_ff == ST_SEP)
      else $error("last sample of a symbol did not start the mirrored half");

   a_mirror_end: assert property (@(posedge clock) disable iff (reset)
      cmd.load && cmd.last |=> state_ff == ST_PASS && pos_ff == hssb_pkg::FIRST_IDX)
      else $error("mirrored half did not end at the start of a symbol");

   a_no_store_at_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> pos_ff != hssb_pkg::FIRST_IDX)
      else $error("zeroth subcarrier written to store");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= hssb_pkg::LAST_IDX)
      else $error("symbol position out of range");

   a_conj_from_top: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEP |-> rd_addr_ff == hssb_pkg::LAST_IDX)
      else $error("mirrored read does not start at the last sample");

endmodule

### src/hssb_datapath.sv
module hssb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  hssb_pkg::sample_type  in_sample,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_re,
   output logic signed [15:0]    rsp_im,
   output logic                  rsp_last,
   input  hssb_pkg::cmd_type     cmd,
   output hssb_pkg::status_type  status
);

   hssb_pkg::sample_type store_mem [hssb_pkg::SYMBOL_LEN];
   hssb_pkg::sample_type rd_data_ff;
   logic                 out_valid_ff, out_valid_in;
   logic signed [15:0]   out_re_ff, out_re_in;
   logic signed [15:0]   out_im_ff, out_im_in;
   logic                 out_last_ff, out_last_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[cmd.wr_addr] <= in_sample;
      end
      rd_data_ff <= store_mem[cmd.rd_addr];
   end

   assign status.load_ok = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      out_last_in  = out_last_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
         out_last_in  = cmd.last;
         case (cmd.sel)
            hssb_pkg::SEL_SAMPLE: begin
               out_re_in = in_sample.re;
               out_im_in = in_sample.im;
            end
            hssb_pkg::SEL_CONJ: begin
               out_re_in = rd_data_ff.re;
               out_im_in = hssb_pkg::sat_negate(rd_data_ff.im);
            end
            default: begin
               out_re_in = '0;
               out_im_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_re_ff   <= out_re_in;
      out_im_ff   <= out_im_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_re    = out_re_ff;
   assign rsp_im    = out_im_ff;
   assign rsp_last  = out_last_ff;

endmodule

### src/hermitian_symmetric_subcarrier_builder.sv
// a result stands on the response channel in the cycle after its request is taken
// throughput: one request per cycle within a symbol while the sink is ready; the last
// request of a symbol is followed by SYMBOL_LEN further results, set by the single store
// read port, one per cycle while the sink is ready
// reset: symbol position, sequencer state and response valid clear; the sample store
// is not cleared, every entry is written in a symbol before it is read there
module hermitian_symmetric_subcarrier_builder (
   input  logic        clock,
   input  logic        reset,
   hssb_req_if.sink    req_ch,
   hssb_rsp_if.source  rsp_ch
);

   hssb_pkg::cmd_type    cmd;
   hssb_pkg::status_type status;
   hssb_pkg::sample_type in_sample;
   logic                 req_ready;

   assign in_sample.re = req_ch.in_re;
   assign in_sample.im = req_ch.in_im;
   assign req_ch.ready = req_ready;

   hssb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hssb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_sample (in_sample),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_re    (rsp_ch.out_re),
      .rsp_im    (rsp_ch.out_im),
      .rsp_last  (rsp_ch.last_of_symbol),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
